// ===== src/svm_pkg.sv =====
// shared widths and the control type for the stereo volume mixer
`default_nettype none

package svm_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int VOL_W      = 16;
  localparam int ACC_W      = 32;
  localparam int GAIN_SHIFT = 16;
  localparam int PROD_W     = SAMPLE_W + VOL_W + 2;

  typedef struct packed {
    logic load;
    logic accumulate;
    logic clear;
  } svm_ctl_t;

endpackage

`default_nettype wire

// ===== src/svm_in_if.sv =====
// request channel carrying one channel's stereo contribution
`default_nettype none

interface svm_in_if;
  import svm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;
  logic [VOL_W-1:0]           left_volume;
  logic [VOL_W-1:0]           right_volume;
  logic                       mono;
  logic                       last_contribution;

  modport source (
    output valid, left_sample, right_sample, left_volume, right_volume, mono,
           last_contribution,
    input  ready
  );

  modport sink (
    input  valid, left_sample, right_sample, left_volume, right_volume, mono,
           last_contribution,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/svm_out_if.sv =====
// request channel carrying one mixed stereo frame
`default_nettype none

interface svm_out_if;
  import svm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;

  modport source (
    output valid, left_out, right_out,
    input  ready
  );

  modport sink (
    input  valid, left_out, right_out,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/svm_side.sv =====
// one side of the mixer: gain multiply, scale, saturating accumulate
`default_nettype none

module svm_side import svm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  svm_ctl_t                   ctl,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [VOL_W-1:0]           volume,
  output logic signed [SAMPLE_W-1:0] mix
);

  localparam int SCALED_W = PROD_W - GAIN_SHIFT;

  logic signed [PROD_W-1:0]   product;
  logic signed [PROD_W-1:0]   product_next;
  logic signed [SCALED_W-1:0] scaled_wide;
  logic signed [SAMPLE_W-1:0] scaled;
  logic signed [ACC_W:0]      sum_wide;
  logic signed [ACC_W-1:0]    sum_sat;
  logic signed [ACC_W-1:0]    acc;

  // volume doubled so that half scale is unity
  assign product_next = PROD_W'(sample) * PROD_W'($signed({1'b0, volume, 1'b0}));

  assign scaled_wide = product[PROD_W-1:GAIN_SHIFT];

  always_comb begin
    if (scaled_wide[SCALED_W-1:SAMPLE_W-1] == '0 ||
        scaled_wide[SCALED_W-1:SAMPLE_W-1] == '1) begin
      scaled = scaled_wide[SAMPLE_W-1:0];
    end else if (scaled_wide[SCALED_W-1]) begin
      scaled = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      scaled = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  assign sum_wide = (ACC_W+1)'(acc) + (ACC_W+1)'(scaled);

  always_comb begin
    if (sum_wide[ACC_W] == sum_wide[ACC_W-1]) begin
      sum_sat = sum_wide[ACC_W-1:0];
    end else if (sum_wide[ACC_W]) begin
      sum_sat = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  always_comb begin
    if (sum_sat[ACC_W-1:SAMPLE_W-1] == '0 || sum_sat[ACC_W-1:SAMPLE_W-1] == '1) begin
      mix = sum_sat[SAMPLE_W-1:0];
    end else if (sum_sat[ACC_W-1]) begin
      mix = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      mix = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      product <= product_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctl.accumulate) begin
      acc <= ctl.clear ? '0 : sum_sat;
    end
  end

endmodule

`default_nettype wire

// ===== src/stereo_volume_mixer_core.sv =====
// Stereo volume mixer: each request adds one channel's scaled stereo frame into
// two saturating 32-bit sums; a request marked last emits both sums clamped to
// 16 bits and clears them. One request is taken every clock cycle; a held
// output stalls only marked requests behind it. A request passes an input
// register and a product register; a marked frame is registered at the output
// with the accumulator update. The rate is set by the accumulator loop, one
// saturating add per side per cycle.
`default_nettype none

module stereo_volume_mixer_core import svm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  svm_in_if.sink    sample_in,
  svm_out_if.source mix_out
);

  logic                       v1;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;
  logic [VOL_W-1:0]           left_volume;
  logic [VOL_W-1:0]           right_volume;
  logic                       mono;
  logic                       last1;
  logic                       v2;
  logic                       last2;
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;

  logic                       in_take;
  logic                       adv1;
  logic                       adv2;
  logic                       out_free;
  logic signed [SAMPLE_W-1:0] right_src;
  logic signed [SAMPLE_W-1:0] left_mix;
  logic signed [SAMPLE_W-1:0] right_mix;
  svm_ctl_t                   ctl;

  assign out_free = !out_valid || mix_out.ready;
  assign adv2     = v2 && (!last2 || out_free);
  assign adv1     = v1 && (!v2 || adv2);
  assign in_take  = sample_in.valid && sample_in.ready;

  assign sample_in.ready = !v1 || adv1;
  assign mix_out.valid   = out_valid;
  assign mix_out.left_out  = left_out;
  assign mix_out.right_out = right_out;

  assign right_src = mono ? left_sample : right_sample;

  assign ctl.load       = adv1;
  assign ctl.accumulate = adv2;
  assign ctl.clear      = last2;

  always_ff @(posedge clk) begin
    if (in_take) begin
      left_sample  <= sample_in.left_sample;
      right_sample <= sample_in.right_sample;
      left_volume  <= sample_in.left_volume;
      right_volume <= sample_in.right_volume;
      mono         <= sample_in.mono;
      last1        <= sample_in.last_contribution;
    end
    if (adv1) begin
      last2 <= last1;
    end
    if (adv2 && last2) begin
      left_out  <= left_mix;
      right_out <= right_mix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        v1 <= 1'b1;
      end else if (adv1) begin
        v1 <= 1'b0;
      end
      if (adv1) begin
        v2 <= 1'b1;
      end else if (adv2) begin
        v2 <= 1'b0;
      end
      if (adv2 && last2) begin
        out_valid <= 1'b1;
      end else if (mix_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  svm_side u_left (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .sample (left_sample),
    .volume (left_volume),
    .mix    (left_mix)
  );

  svm_side u_right (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .sample (right_src),
    .volume (right_volume),
    .mix    (right_mix)
  );

endmodule

`default_nettype wire

// ===== src/svm_checker.sv =====
// port-level checks for the stereo volume mixer and their bind
`default_nettype none

module svm_checker import svm_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] left_out,
  input logic signed [SAMPLE_W-1:0] right_out
);

  // a frame waiting at the output stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output frame dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(left_out) && $stable(right_out))
    else $error("output frame changed while stalled");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output frame present after reset");

  a_rst_ready: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind stereo_volume_mixer_core svm_checker u_svm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (sample_in.ready),
  .out_valid (mix_out.valid),
  .out_ready (mix_out.ready),
  .left_out  (mix_out.left_out),
  .right_out (mix_out.right_out)
);

`default_nettype wire

// ===== bench/tb.sv =====
// self-checking testbench for the stereo volume mixer core
`timescale 1ns / 1ps

module tb;
  import svm_pkg::*;

  localparam int  CYCLE_LIMIT  = 400000;
  localparam int  RANDOM_ITEMS = 1000;
  localparam int  HOLD_CYCLES  = 300;
  localparam int  SAT_RUN      = 40;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic [VOL_W-1:0]           left_volume;
    logic [VOL_W-1:0]           right_volume;
    logic                       mono;
    logic                       last_contribution;
  } chan_req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
  } mix_frame_t;

  class mix_scoreboard;
    int         left_sum;
    int         right_sum;
    mix_frame_t frames_due[$];
    int         mismatches;
    int         failures;

    function new();
      left_sum   = 0;
      right_sum  = 0;
      mismatches = 0;
      failures   = 0;
    endfunction

    function longint scale_side(logic signed [SAMPLE_W-1:0] sample, logic [VOL_W-1:0] gain);
      longint prod;
      longint q;
      prod = longint'(sample) * longint'({gain, 1'b0});
      q = prod >>> GAIN_SHIFT;
      if (q < -32768) q = -32768;
      if (q > 32767) q = 32767;
      return q;
    endfunction

    function int sat_add(int acc, longint v);
      longint s;
      s = longint'(acc) + v;
      if (s < -longint'(2147483647) - 1) s = -longint'(2147483647) - 1;
      if (s > 2147483647) s = 2147483647;
      return int'(s);
    endfunction

    function logic signed [SAMPLE_W-1:0] clamp16(int v);
      if (v < -32768) return 16'sh8000;
      if (v > 32767) return 16'sh7fff;
      return v[SAMPLE_W-1:0];
    endfunction

    function void note_request(chan_req_t r);
      logic signed [SAMPLE_W-1:0] rs;
      mix_frame_t                 f;
      rs = r.mono ? r.left_sample : r.right_sample;
      left_sum  = sat_add(left_sum, scale_side(r.left_sample, r.left_volume));
      right_sum = sat_add(right_sum, scale_side(rs, r.right_volume));
      if (r.last_contribution) begin
        f.left_out  = clamp16(left_sum);
        f.right_out = clamp16(right_sum);
        frames_due = {frames_due, f};
        left_sum  = 0;
        right_sum = 0;
      end
    endfunction

    function void check_frame(logic signed [SAMPLE_W-1:0] lo, logic signed [SAMPLE_W-1:0] ro);
      mix_frame_t f;
      if (frames_due.size() == 0) begin
        failures++;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected frame: left %0d right %0d", lo, ro);
        return;
      end
      f = frames_due.pop_front();
      if (f.left_out !== lo || f.right_out !== ro) begin
        failures++;
        mismatches++;
        if (mismatches <= 10)
          $display("frame mismatch: expected left %0d right %0d, got left %0d right %0d",
                   f.left_out, f.right_out, lo, ro);
      end
    endfunction

    function int pending();
      return frames_due.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   gaps_on;
  bit   hold_req;
  int   hold_left;
  int   cycles;
  int   n_sent;

  mix_scoreboard sb = new();

  svm_in_if  req_if ();
  svm_out_if mix_if ();

  stereo_volume_mixer_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .sample_in (req_if),
    .mix_out   (mix_if)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // receiver side: random stalls and one long hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      mix_if.ready = 1'b0;
      hold_left--;
    end else begin
      mix_if.ready = !(gaps_on && $urandom_range(0, 99) < 10);
    end
  end

  always @(posedge clk) begin
    if (!rst && mix_if.valid && mix_if.ready)
      sb.check_frame(mix_if.left_out, mix_if.right_out);
  end

  function automatic chan_req_t mk_req(int ls, int rs, int lv, int rv, bit m, bit lst);
    chan_req_t r;
    r.left_sample       = ls[SAMPLE_W-1:0];
    r.right_sample      = rs[SAMPLE_W-1:0];
    r.left_volume       = lv[VOL_W-1:0];
    r.right_volume      = rv[VOL_W-1:0];
    r.mono              = m;
    r.last_contribution = lst;
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'(int'($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [VOL_W-1:0] pick_volume();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'h8000;
      2:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic drive_request(chan_req_t r);
    @(negedge clk);
    while (gaps_on && $urandom_range(0, 99) < 10) begin
      req_if.valid             = 1'b0;
      req_if.left_sample       = 16'($urandom);
      req_if.right_sample      = 16'($urandom);
      req_if.last_contribution = 1'($urandom);
      @(negedge clk);
    end
    req_if.valid             = 1'b1;
    req_if.left_sample       = r.left_sample;
    req_if.right_sample      = r.right_sample;
    req_if.left_volume       = r.left_volume;
    req_if.right_volume      = r.right_volume;
    req_if.mono              = r.mono;
    req_if.last_contribution = r.last_contribution;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sb.note_request(r);
    n_sent++;
  endtask

  task automatic send_random_frame(int channels);
    chan_req_t r;
    for (int i = 0; i < channels; i++) begin
      r.left_sample       = pick_sample();
      r.right_sample      = pick_sample();
      r.left_volume       = pick_volume();
      r.right_volume      = pick_volume();
      r.mono              = ($urandom_range(0, 99) < 30);
      r.last_contribution = (i == channels - 1);
      drive_request(r);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    bit held;
    bit paused;
    int max_chan;

    rst                      = 1'b1;
    gaps_on                  = 1'b1;
    hold_req                 = 1'b0;
    hold_left                = 0;
    cycles                   = 0;
    n_sent                   = 0;
    held                     = 1'b0;
    paused                   = 1'b0;
    req_if.valid             = 1'b0;
    req_if.left_sample       = '0;
    req_if.right_sample      = '0;
    req_if.left_volume       = '0;
    req_if.right_volume      = '0;
    req_if.mono              = 1'b0;
    req_if.last_contribution = 1'b0;
    mix_if.ready             = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: unity, wide product, zero gain, mono, floor, output clamp, cancel
    drive_request(mk_req(1234, -5678, 32768, 32768, 0, 1));
    drive_request(mk_req(-32768, 32767, 65535, 65535, 0, 1));
    drive_request(mk_req(32767, -32768, 0, 0, 0, 1));
    drive_request(mk_req(-20000, 12345, 32768, 16384, 1, 1));
    drive_request(mk_req(-1, 1, 1, 1, 0, 1));
    drive_request(mk_req(30000, -30000, 32768, 32768, 0, 0));
    drive_request(mk_req(30000, -30000, 32768, 32768, 0, 0));
    drive_request(mk_req(30000, -30000, 32768, 32768, 0, 1));
    drive_request(mk_req(32767, -32768, 65535, 0, 1, 1));
    drive_request(mk_req(10000, -10000, 32768, 32768, 0, 0));
    drive_request(mk_req(-10000, 10000, 32768, 32768, 0, 1));

    // long unmarked run: sums grow far past the output range
    gaps_on = 1'b0;
    for (int i = 0; i < SAT_RUN; i++)
      drive_request(mk_req(32767, -32768, 65535, 65535, 0, i == SAT_RUN - 1));
    gaps_on = 1'b1;
    wait_drained();

    n_sent = 0;
    while (n_sent < RANDOM_ITEMS) begin
      max_chan = 8;
      if (!held && n_sent >= 300) begin
        held     = 1'b1;
        hold_req = 1'b1;
      end
      if (n_sent >= 300 && n_sent < 420)
        max_chan = 2;
      if (!paused && n_sent >= 500) begin
        paused = 1'b1;
        wait_drained();
      end
      gaps_on = !(n_sent >= 600 && n_sent < 800);
      send_random_frame($urandom_range(1, max_chan));
    end
    gaps_on = 1'b1;

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.failures == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== stereo_volume_mixer_core.f =====
src/svm_pkg.sv
src/svm_in_if.sv
src/svm_out_if.sv
src/svm_side.sv
src/stereo_volume_mixer_core.sv
src/svm_checker.sv
bench/tb.sv
